@@ rtl/core/lrc_pkg.sv @@
// Shared types, constants and table helpers for the Lanczos rate converter.
package lrc_pkg;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  localparam int STEP_W     = 21;
  localparam int GAIN_W     = 17;
  localparam int KS_W       = 23;
  localparam int HW_W       = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int DIST_W     = 26;
  localparam int KI_W       = DIST_W + KS_W;
  localparam int ACC_W      = 47;
  localparam int GAIN_ONE   = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP   = 3'd0,
    CFG_GAIN   = 3'd1,
    CFG_KSCALE = 3'd2,
    CFG_HWIN   = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] absd;
  } tap_t;

  typedef struct packed {
    logic valid;
    logic busy;
  } mac_stat_t;

  // sin(pi*t), t unsigned Q30, result signed Q30
  function automatic longint sin_pi(input longint unsigned t);
    longint unsigned whole;
    longint unsigned f;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned r;
    longint s;
    whole = t >> 30;
    f = t & (Q30_ONE - 64'd1);
    if (f > (Q30_ONE >> 1)) f = Q30_ONE - f;
    u  = (f * PI_Q30) >> 30;
    u2 = (u * u) >> 30;
    r  = Q30_ONE;
    r  = Q30_ONE - ((u2 * r) >> 30) / 110;
    r  = Q30_ONE - ((u2 * r) >> 30) / 72;
    r  = Q30_ONE - ((u2 * r) >> 30) / 42;
    r  = Q30_ONE - ((u2 * r) >> 30) / 20;
    r  = Q30_ONE - ((u2 * r) >> 30) / 6;
    s  = longint'((u * r) >> 30);
    return whole[0] ? -s : s;
  endfunction

endpackage

@@ rtl/core/lrc_weight_mac.sv @@
// Tap pipeline: kernel index multiply, table interpolation and sample product.
module lrc_weight_mac #(
  parameter int QUALITY        = 3,
  parameter int STEPS_PER_LOBE = 64,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrc_pkg::tap_t                       tap_i,
  input  logic signed [SAMPLE_BITS-1:0]       smp_i,
  input  logic [lrc_pkg::KS_W-1:0]            kscale_i,
  output lrc_pkg::mac_stat_t                  stat_o,
  output logic signed [SAMPLE_BITS+25:0]      prod_o
);
  import lrc_pkg::*;

  localparam int TABLE_LAST = QUALITY * STEPS_PER_LOBE;
  localparam int TW         = $clog2(TABLE_LAST + 1);
  localparam int IDX_W      = KI_W - 32;

  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((n >> b) & 64'd1);
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [15:0] weight_entry(input longint unsigned i);
    longint unsigned pi2;
    longint s1;
    longint s2;
    longint p;
    logic neg;
    longint unsigned m;
    longint unsigned num;
    longint unsigned den;
    longint unsigned w;
    pi2 = (PI_Q30 * PI_Q30) >> 30;
    if (i == 0) return 16'sd16384;
    s1  = sin_pi((i << 30) / STEPS_PER_LOBE);
    s2  = sin_pi((i << 30) / TABLE_LAST);
    p   = s1 * s2;
    neg = p < 0;
    m   = longint'(neg ? -p : p) >> 30;
    num = m * QUALITY * STEPS_PER_LOBE * STEPS_PER_LOBE;
    den = (pi2 * i * i) >> 14;
    w   = udiv(num + (den >> 1), den);
    if (w > 32767) w = 32767;
    return neg ? -16'(w) : 16'(w);
  endfunction

  logic signed [15:0] wtab [TABLE_LAST+1];

  for (genvar gi = 0; gi <= TABLE_LAST; gi++) begin : g_tab
    localparam logic signed [15:0] ENTRY = weight_entry(longint'(gi));
    assign wtab[gi] = ENTRY;
  end

  logic                          v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [DIST_W-1:0]             absd1_r;
  logic [KI_W-1:0]               ki2_r;
  logic signed [SAMPLE_BITS-1:0] smp2_r, smp3_r, smp4_r;
  logic signed [15:0]            e0_3_r;
  logic signed [16:0]            diff3_r;
  logic [15:0]                   fr3_r;
  logic signed [33:0]            w30_4_r;
  logic signed [SAMPLE_BITS+25:0] prod5_r;

  logic [IDX_W-1:0]   idx;
  logic [IDX_W:0]     idx1;
  logic signed [15:0] e0, e1;
  logic signed [33:0] ip;
  logic signed [33:0] w30;
  logic signed [33:0] w22w;
  logic signed [25:0] w22;

  assign idx  = ki2_r[KI_W-1:32];
  assign idx1 = {1'b0, idx} + (IDX_W+1)'(1);
  assign e0   = (idx <= IDX_W'(TABLE_LAST)) ? wtab[idx[TW-1:0]] : 16'sd0;
  assign e1   = (idx1 <= (IDX_W+1)'(TABLE_LAST)) ? wtab[idx1[TW-1:0]] : 16'sd0;
  assign ip   = diff3_r * $signed({1'b0, fr3_r});
  assign w30  = (34'(e0_3_r) <<< 16) + ip;
  assign w22w = (w30_4_r + 34'sd128) >>> 8;
  assign w22  = w22w[25:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= tap_i.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    absd1_r <= tap_i.absd;
    ki2_r   <= KI_W'(absd1_r) * KI_W'(kscale_i);
    smp2_r  <= smp_i;
    e0_3_r  <= e0;
    diff3_r <= 17'(e1) - 17'(e0);
    fr3_r   <= ki2_r[31:16];
    smp3_r  <= smp2_r;
    w30_4_r <= w30;
    smp4_r  <= smp3_r;
    prod5_r <= smp4_r * w22;
  end

  assign stat_o.valid = v5_r;
  assign stat_o.busy  = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign prod_o       = prod5_r;

endmodule

@@ rtl/core/lanczos_rate_converter_unit.sv @@
// Lanczos rate converter top level: sample ring memory, position control, output stage.
// Per input: for each output (at most MAX_OUTPUTS), 2*w-1 taps go through
// the single-port-read ring and the 5-stage tap MAC, then gain, rounding and saturation.
// One input at a time; a finished result waits in the output register, the next one
// holds in S_EMIT while that register is full and stalled.
// Reset (rst_n low, synchronous) clears control state, then a clearing pass writes zero
// to all HISTORY_DEPTH ring entries with in_stall high; config writes are taken.
module lanczos_rate_converter_unit #(
  parameter int QUALITY         = 3,
  parameter int STEPS_PER_LOBE  = 64,
  parameter int HISTORY_DEPTH   = 256,
  parameter int MAX_HALF_WINDOW = 64,
  parameter int MAX_OUTPUTS     = 8,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  output logic                              out_last_of_run,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lrc_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int PW = $clog2(HISTORY_DEPTH + 2 * MAX_HALF_WINDOW) + 2;
  localparam int WW = $clog2(MAX_HALF_WINDOW + 1);
  localparam int KW = WW + 1;
  localparam int CW = $clog2(MAX_OUTPUTS + 1);
  localparam int PRW = SAMPLE_BITS + 26;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_WRAP, S_RUN, S_MLO, S_MHI, S_RND, S_EMIT
  } state_t;

  state_t state_r;

  logic [STEP_W-1:0] step_r;
  logic [GAIN_W-1:0] gain_r;
  logic [KS_W-1:0]   ks_r;
  logic [HW_W-1:0]   hw_r;

  logic [AW-1:0]        wp_r, newest_r, clr_r, addr_r;
  logic signed [31:0]   rp_r;
  logic [CW-1:0]        cnt_r;
  logic [GAIN_W-1:0]    geff_r;
  logic [WW-1:0]        weff_r;
  logic [15:0]          frac_r;
  logic signed [PW-1:0] addr_s_r;
  logic signed [KW-1:0] k_r;
  logic [KW-1:0]        tap_left_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [40:0]          plo_r;
  logic signed [40:0]   phi_r;
  logic signed [SAMPLE_BITS-1:0] res_r;
  logic                 out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                 out_last_r;

  logic signed [SAMPLE_BITS-1:0] ring [HISTORY_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata_r;
  logic                          ring_we;
  logic [AW-1:0]                 ring_wa;
  logic signed [SAMPLE_BITS-1:0] ring_wd;

  tap_t               tap;
  mac_stat_t          stat;
  logic signed [PRW-1:0] prod;

  logic [WW-1:0]      weff_c;
  logic [GAIN_W-1:0]  geff_c;
  logic signed [33:0] newest_s, weff_s, rp_s, wlim, start_s, kst_s, rp_dec;
  logic signed [33:0] d_s, absd_s;
  logic               more_c;
  logic               accept;
  logic signed [47:0] acc_sum;
  logic signed [65:0] y_s, r_s;

  assign accept    = (state_r == S_IDLE) && in_valid;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign weff_c = (hw_r == '0) ? WW'(1) :
                  ((32'(hw_r) > 32'(MAX_HALF_WINDOW)) ? WW'(MAX_HALF_WINDOW) : WW'(hw_r));
  assign geff_c = (32'(gain_r) > 32'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : gain_r;

  assign newest_s = $signed({{(34-AW){1'b0}}, newest_r});
  assign weff_s   = $signed({{(34-WW){1'b0}}, weff_r});
  assign rp_s     = 34'(rp_r);
  assign wlim     = -(weff_s <<< 16);
  assign more_c   = (cnt_r < CW'(MAX_OUTPUTS)) && (rp_s <= wlim);
  assign start_s  = newest_s + (rp_s >>> 16) + 34'sd1 - weff_s;
  assign kst_s    = 34'sd1 - weff_s;
  assign rp_dec   = rp_s - 34'sd65536;

  assign d_s    = (34'(k_r) <<< 16) - $signed({18'b0, frac_r});
  assign absd_s = (d_s < 0) ? -d_s : d_s;
  assign tap.valid = (state_r == S_RUN) && (tap_left_r != '0);
  assign tap.absd  = absd_s[DIST_W-1:0];

  assign acc_sum = 48'(acc_r) + 48'(prod);

  assign y_s = (66'(phi_r) <<< 24) + $signed({25'b0, plo_r});
  assign r_s = (y_s + (66'sd1 <<< 37)) >>> 38;

  assign ring_we = (state_r == S_CLEAR) || accept;
  assign ring_wa = (state_r == S_CLEAR) ? clr_r : wp_r;
  assign ring_wd = (state_r == S_CLEAR) ? '0 : in_sample;

  always_ff @(posedge clk) begin
    if (ring_we) ring[ring_wa] <= ring_wd;
    rdata_r <= ring[addr_r];
  end

  lrc_weight_mac #(
    .QUALITY(QUALITY), .STEPS_PER_LOBE(STEPS_PER_LOBE), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk(clk), .rst_n(rst_n), .tap_i(tap), .smp_i(rdata_r), .kscale_i(ks_r),
    .stat_o(stat), .prod_o(prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_W'(65536);
      gain_r      <= GAIN_W'(65536);
      ks_r        <= KS_W'(4194304);
      hw_r        <= HW_W'(3);
      tap_left_r  <= '0;
      acc_r       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_STEP:   step_r <= cfg_data[STEP_W-1:0];
          CFG_GAIN:   gain_r <= cfg_data[GAIN_W-1:0];
          CFG_KSCALE: ks_r   <= cfg_data[KS_W-1:0];
          CFG_HWIN:   hw_r   <= cfg_data[HW_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && state_r != S_EMIT) out_valid_r <= 1'b0;

      if (stat.valid) begin
        if (acc_sum[47] != acc_sum[46])
          acc_r <= acc_sum[47] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
          acc_r <= acc_sum[ACC_W-1:0];
      end

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(HISTORY_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            newest_r <= wp_r;
            wp_r     <= (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
            cnt_r    <= '0;
            weff_r   <= weff_c;
            geff_r   <= geff_c;
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (more_c) begin
            frac_r     <= rp_r[15:0];
            addr_s_r   <= PW'(start_s);
            k_r        <= KW'(kst_s);
            tap_left_r <= KW'({weff_r, 1'b0}) - KW'(1);
            acc_r      <= '0;
            state_r    <= S_WRAP;
          end else begin
            if (rp_dec < -(34'sd65536 * 34'(HISTORY_DEPTH)))
              rp_r <= 32'(-(34'sd65536 * 34'(HISTORY_DEPTH)));
            else
              rp_r <= 32'(rp_dec);
            state_r <= S_IDLE;
          end
        end
        S_WRAP: begin
          if (addr_s_r < 0) begin
            addr_s_r <= addr_s_r + PW'(HISTORY_DEPTH);
          end else if (addr_s_r >= PW'(HISTORY_DEPTH)) begin
            addr_s_r <= addr_s_r - PW'(HISTORY_DEPTH);
          end else begin
            addr_r  <= addr_s_r[AW-1:0];
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (tap_left_r != '0) begin
            addr_r     <= (addr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : addr_r + AW'(1);
            k_r        <= k_r + KW'(1);
            tap_left_r <= tap_left_r - KW'(1);
          end else if (!stat.busy) begin
            state_r <= S_MLO;
          end
        end
        S_MLO: begin
          plo_r   <= 41'(acc_r[23:0]) * 41'(geff_r);
          state_r <= S_MHI;
        end
        S_MHI: begin
          phi_r   <= $signed(acc_r[ACC_W-1:24]) * $signed({1'b0, geff_r});
          state_r <= S_RND;
        end
        S_RND: begin
          if (r_s > 66'((1 <<< (SAMPLE_BITS - 1)) - 1))
            res_r <= SAMPLE_BITS'((1 <<< (SAMPLE_BITS - 1)) - 1);
          else if (r_s < -(66'sd1 <<< (SAMPLE_BITS - 1)))
            res_r <= SAMPLE_BITS'(-(1 <<< (SAMPLE_BITS - 1)));
          else
            res_r <= r_s[SAMPLE_BITS-1:0];
          rp_r    <= rp_r + $signed({11'b0, step_r});
          cnt_r   <= cnt_r + CW'(1);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= res_r;
            out_last_r   <= !more_c;
            state_r      <= S_CHECK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_last_of_run = out_last_r;

endmodule

@@ rtl/core/lrc_checker.sv @@
// Port-level assertions for the rate converter top level, with bind.
module lrc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_sample,
  input logic                   out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in work");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during ring clear");

endmodule

bind lanczos_rate_converter_unit lrc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lrc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
  .out_last_of_run(out_last_of_run)
);
